@@ hdl/lnm_pkg.sv @@
// Package for the Levenshtein near-match unit: request/result types, queue entry
// types, operation codes and sizing constants. No dependencies.
`timescale 1ns / 1ps

package lnm_pkg;

    localparam int LNM_MAX_LEN     = 256;
    localparam int LNM_QUEUE_DEPTH = 4;
    localparam int LNM_DIST_W      = 9;
    localparam int LNM_DIST_LIMIT  = 511;
    localparam int LNM_CH_W        = 8;

    localparam logic [8:0] LNM_NEAR_MAX_RESET = 9'd5;

    localparam logic [1:0] FUNC_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] FUNC_APPEND_SECOND = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE       = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND_FIRST,
        OP_APPEND_SECOND,
        OP_COMPUTE
    } lnm_op_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [LNM_CH_W-1:0] ch;
    } lnm_req_t;

    typedef struct packed {
        logic [LNM_DIST_W-1:0] distance;
        logic                  is_exact;
        logic                  is_near;
        logic                  truncated;
    } lnm_res_t;

    typedef struct packed {
        lnm_op_t             op;
        logic [LNM_CH_W-1:0] ch;
    } lnm_entry_t;

    typedef struct packed {
        logic       push;
        lnm_entry_t entry;
    } lnm_qwr_t;

    typedef struct packed {
        logic       valid;
        lnm_entry_t entry;
    } lnm_qrd_t;

endpackage

@@ hdl/lnm_front.sv @@
// Front end of the near-match unit: accepts requests and classifies them into
// queue operations. Depends on lnm_pkg.
`timescale 1ns / 1ps

module lnm_front
    import lnm_pkg::*;
(
    input  logic     req_valid,
    output logic     req_ready,
    input  lnm_req_t req_data,
    input  logic     q_full,
    output lnm_qwr_t q_wr
);

    logic    keep;
    lnm_op_t op;

    always_comb
    begin
        keep = 1'b1;
        op   = OP_COMPUTE;
        unique case (req_data.func)
            FUNC_APPEND_FIRST:  op = OP_APPEND_FIRST;
            FUNC_APPEND_SECOND: op = OP_APPEND_SECOND;
            FUNC_COMPUTE:       op = OP_COMPUTE;
            default:            keep = 1'b0;
        endcase
    end

    // drop unused codes: accepted, never queued
    assign req_ready      = !q_full;
    assign q_wr.push      = req_valid && !q_full && keep;
    assign q_wr.entry.op  = op;
    assign q_wr.entry.ch  = req_data.ch;

endmodule

@@ hdl/lnm_queue.sv @@
// Short queue between front and back of the near-match unit.
// Depends on lnm_pkg.
`timescale 1ns / 1ps

module lnm_queue
    import lnm_pkg::*;
#(
    parameter int DEPTH = LNM_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  lnm_qwr_t q_wr,
    input  logic     pop,
    output logic     full,
    output lnm_qrd_t q_rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lnm_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign q_rd.valid  = (count_reg != '0);
    assign q_rd.entry  = mem[rd_ptr_reg];
    assign do_push     = q_wr.push && !full;
    assign do_pop      = pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wr.entry;
        end
    end

endmodule

@@ hdl/lnm_back.sv @@
// Back end of the near-match unit: string stores, cost row and the cell-per-cycle
// edit distance sequencer with the result register. Depends on lnm_pkg.
`timescale 1ns / 1ps

module lnm_back
    import lnm_pkg::*;
#(
    parameter int MAX_LEN = LNM_MAX_LEN
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lnm_qrd_t              q_rd,
    output logic                  pop,
    input  logic [LNM_DIST_W-1:0] near_max,
    output logic                  res_valid,
    input  logic                  res_ready,
    output lnm_res_t              res_data
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int WIDE_W = (LEN_W > LNM_DIST_W) ? LEN_W : LNM_DIST_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROW,
        ST_CELL,
        ST_FIN
    } state_t;

    state_t                state_reg;
    logic [LEN_W-1:0]      first_len_reg, second_len_reg;
    logic                  overflow_reg;
    logic [LEN_W-1:0]      i_reg, j_reg, diag_reg, left_reg, dist_reg;
    logic                  res_valid_reg;
    lnm_res_t              res_data_reg;

    logic [LNM_CH_W-1:0]   first_mem  [MAX_LEN];
    logic [LNM_CH_W-1:0]   second_mem [MAX_LEN];
    logic [LEN_W-1:0]      cost_mem   [MAX_LEN];
    logic [LNM_CH_W-1:0]   a_q, b_q;
    logic [LEN_W-1:0]      up_q;

    logic                  first_full, second_full;
    logic                  first_we, second_we, cost_we;
    logic [LEN_W-1:0]      i_m1, j_m1, up_v, min_v, cell_v;
    logic [ADDR_W-1:0]     fa, ra, cw;
    logic [WIDE_W-1:0]     dist_wide;
    logic [LNM_DIST_W-1:0] dist_sat;

    assign first_full  = (first_len_reg == LEN_W'(MAX_LEN));
    assign second_full = (second_len_reg == LEN_W'(MAX_LEN));
    assign pop         = (state_reg == ST_IDLE) && q_rd.valid;
    assign first_we    = pop && (q_rd.entry.op == OP_APPEND_FIRST) && !first_full;
    assign second_we   = pop && (q_rd.entry.op == OP_APPEND_SECOND) && !second_full;
    assign cost_we     = (state_reg == ST_CELL);

    assign i_m1 = i_reg - 1'b1;
    assign j_m1 = j_reg - 1'b1;
    assign fa   = i_m1[ADDR_W-1:0];
    assign cw   = j_m1[ADDR_W-1:0];

    // prefetch column j+1 while cell j is computed
    always_comb
    begin
        ra = '0;
        if (state_reg == ST_CELL && j_reg < LEN_W'(MAX_LEN))
        begin
            ra = j_reg[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        up_v  = (i_reg == LEN_W'(1)) ? j_reg : up_q;
        min_v = (up_v < left_reg) ? up_v : left_reg;
        if (diag_reg < min_v)
        begin
            min_v = diag_reg;
        end
        cell_v = (a_q == b_q) ? diag_reg : min_v + 1'b1;
    end

    assign dist_wide = WIDE_W'(dist_reg);
    assign dist_sat  = (dist_wide > WIDE_W'(LNM_DIST_LIMIT)) ? LNM_DIST_W'(LNM_DIST_LIMIT)
                                                             : dist_wide[LNM_DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[first_len_reg[ADDR_W-1:0]] <= q_rd.entry.ch;
        end
        if (state_reg == ST_ROW)
        begin
            a_q <= first_mem[fa];
        end
    end

    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_mem[second_len_reg[ADDR_W-1:0]] <= q_rd.entry.ch;
        end
        b_q <= second_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[cw] <= cell_v;
        end
        up_q <= cost_mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            overflow_reg   <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            diag_reg       <= '0;
            left_reg       <= '0;
            dist_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_data_reg   <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (q_rd.entry.op)
                            OP_APPEND_FIRST:
                            begin
                                if (first_full)
                                begin
                                    overflow_reg <= 1'b1;
                                end
                                else
                                begin
                                    first_len_reg <= first_len_reg + 1'b1;
                                end
                            end
                            OP_APPEND_SECOND:
                            begin
                                if (second_full)
                                begin
                                    overflow_reg <= 1'b1;
                                end
                                else
                                begin
                                    second_len_reg <= second_len_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_START;
                            end
                        endcase
                    end
                end
                ST_START:
                begin
                    if (first_len_reg == '0 || second_len_reg == '0)
                    begin
                        dist_reg  <= (first_len_reg == '0) ? second_len_reg : first_len_reg;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        i_reg     <= LEN_W'(1);
                        state_reg <= ST_ROW;
                    end
                end
                ST_ROW:
                begin
                    diag_reg  <= i_m1;
                    left_reg  <= i_reg;
                    j_reg     <= LEN_W'(1);
                    state_reg <= ST_CELL;
                end
                ST_CELL:
                begin
                    left_reg <= cell_v;
                    diag_reg <= up_v;
                    if (j_reg == second_len_reg)
                    begin
                        if (i_reg == first_len_reg)
                        begin
                            dist_reg  <= cell_v;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_ROW;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_FIN:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg          <= 1'b1;
                        res_data_reg.distance  <= dist_sat;
                        res_data_reg.is_exact  <= (dist_sat == '0);
                        res_data_reg.is_near   <= (dist_sat != '0) && (dist_sat <= near_max);
                        res_data_reg.truncated <= overflow_reg;
                        first_len_reg          <= '0;
                        second_len_reg         <= '0;
                        overflow_reg           <= 1'b0;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

@@ hdl/levenshtein_near_match_unit.sv @@
// Channel   Signals                        Moves
// req       req_valid/req_ready/req_data   one request: append a char or compute
// res       res_valid/res_ready/res_data   one result per compute request
// cfg       cfg_we/cfg_wdata               near_max register, written while cfg_we is high
//
// Append requests retire in the back end as they are popped while it is idle. A compute
// request steps through start, then per row a row setup and one cell per cycle from
// the cost-row memory, then finish; with an empty string it goes from start to finish.
// Reset is asynchronous, active low; string lengths and the result register clear.
// A stalled result holds the back end at its next finish; the request side keeps filling the queue.
//
// Top level: lnm_front, lnm_queue, lnm_back and the near_max register.
// Depends on lnm_pkg.
`timescale 1ns / 1ps

module levenshtein_near_match_unit
    import lnm_pkg::*;
#(
    parameter int MAX_LEN     = LNM_MAX_LEN,
    parameter int QUEUE_DEPTH = LNM_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  lnm_req_t              req_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output lnm_res_t              res_data,
    input  logic                  cfg_we,
    input  logic [LNM_DIST_W-1:0] cfg_wdata
);

    logic [LNM_DIST_W-1:0] near_max_reg;
    lnm_qwr_t              q_wr;
    lnm_qrd_t              q_rd;
    logic                  q_full;
    logic                  q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_max_reg <= LNM_NEAR_MAX_RESET;
        end
        else if (cfg_we)
        begin
            near_max_reg <= cfg_wdata;
        end
    end

    lnm_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    lnm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    lnm_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .pop       (q_pop),
        .near_max  (near_max_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

@@ hdl/lnm_checker.sv @@
// Port-level checker for the near-match unit and its bind to the top level.
// Depends on lnm_pkg and levenshtein_near_match_unit.
`timescale 1ns / 1ps

module lnm_checker
    import lnm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     res_valid,
    input logic     res_ready,
    input lnm_res_t res_data
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result dropped or changed while stalled");

    a_exact_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.is_exact == (res_data.distance == '0)))
        else $error("exact flag disagrees with distance");

    a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.is_exact && res_data.is_near))
        else $error("exact and near flags both set");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind levenshtein_near_match_unit lnm_checker u_lnm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

@@ dv/lnm_distance_checker.sv @@
// Checker for the Levenshtein near-match unit: tracks the loaded strings and near_max,
// predicts each compute result and compares it with the result channel.
// Depends on lnm_pkg.
`timescale 1ns / 1ps

module lnm_distance_checker
    import lnm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  lnm_req_t              req_data,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  lnm_res_t              res_data,
    input  logic                  cfg_we,
    input  logic [LNM_DIST_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    pending_count
);

    logic [LNM_CH_W-1:0]   first_str [0:LNM_MAX_LEN-1];
    logic [LNM_CH_W-1:0]   second_str [0:LNM_MAX_LEN-1];
    int                    first_cnt;
    int                    second_cnt;
    bit                    chars_dropped;
    logic [LNM_DIST_W-1:0] near_limit;
    lnm_res_t              expected_scores [$];
    int                    mismatches;

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
        mismatches     = 0;
    end

    function automatic int edit_cost();
        int row [0:LNM_MAX_LEN];
        int diag;
        int up;
        int step_cost;
        for (int j = 0; j <= second_cnt; j++)
            row[j] = j;
        for (int i = 1; i <= first_cnt; i++)
        begin
            diag   = row[0];
            row[0] = i;
            for (int j = 1; j <= second_cnt; j++)
            begin
                up = row[j];
                if (first_str[i-1] == second_str[j-1])
                    step_cost = diag;
                else
                begin
                    step_cost = up;
                    if (row[j-1] < step_cost)
                        step_cost = row[j-1];
                    if (diag < step_cost)
                        step_cost = diag;
                    step_cost = step_cost + 1;
                end
                diag   = up;
                row[j] = step_cost;
            end
        end
        return (row[second_cnt] > LNM_DIST_LIMIT) ? LNM_DIST_LIMIT : row[second_cnt];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lnm_res_t want;
        int       cost;
        if (!rst_n)
        begin
            first_cnt     = 0;
            second_cnt    = 0;
            chars_dropped = 1'b0;
            near_limit    = LNM_NEAR_MAX_RESET;
            expected_scores.delete();
        end
        else
        begin
            if (cfg_we)
                near_limit = cfg_wdata;

            if (res_valid && res_ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual distance=%0d",
                             $time, res_data.distance);
                    mismatches++;
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (res_data.distance !== want.distance)
                    begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, want.distance, res_data.distance);
                        mismatches++;
                    end
                    if (res_data.is_exact !== want.is_exact)
                    begin
                        $display("%0t: is_exact expected %0b actual %0b",
                                 $time, want.is_exact, res_data.is_exact);
                        mismatches++;
                    end
                    if (res_data.is_near !== want.is_near)
                    begin
                        $display("%0t: is_near expected %0b actual %0b",
                                 $time, want.is_near, res_data.is_near);
                        mismatches++;
                    end
                    if (res_data.truncated !== want.truncated)
                    begin
                        $display("%0t: truncated expected %0b actual %0b",
                                 $time, want.truncated, res_data.truncated);
                        mismatches++;
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                case (req_data.func)
                    FUNC_APPEND_FIRST:
                    begin
                        if (first_cnt < LNM_MAX_LEN)
                        begin
                            first_str[first_cnt] = req_data.ch;
                            first_cnt++;
                        end
                        else
                            chars_dropped = 1'b1;
                    end
                    FUNC_APPEND_SECOND:
                    begin
                        if (second_cnt < LNM_MAX_LEN)
                        begin
                            second_str[second_cnt] = req_data.ch;
                            second_cnt++;
                        end
                        else
                            chars_dropped = 1'b1;
                    end
                    FUNC_COMPUTE:
                    begin
                        cost           = edit_cost();
                        want.distance  = cost[LNM_DIST_W-1:0];
                        want.is_exact  = (cost == 0);
                        want.is_near   = (cost >= 1) && (cost <= int'(near_limit));
                        want.truncated = chars_dropped;
                        expected_scores.push_back(want);
                        first_cnt     = 0;
                        second_cnt    = 0;
                        chars_dropped = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= expected_scores.size();
    end

endmodule

@@ dv/levenshtein_near_match_unit_tb.sv @@
// Top of the Levenshtein near-match unit testbench: clock, reset, request and result
// traffic, near_max writes and the verdict. Depends on lnm_pkg, the unit and
// lnm_distance_checker.
`timescale 1ns / 1ps

module levenshtein_near_match_unit_tb;
    import lnm_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         SETTLE      = 50;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    lnm_req_t              req_data;
    logic                  res_valid;
    logic                  res_ready;
    lnm_res_t              res_data;
    logic                  cfg_we;
    logic [LNM_DIST_W-1:0] cfg_wdata;

    int                    mismatch_count;
    int                    pending_count;

    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    hold_request;
    int                    hold_left;
    int                    sent_items;
    int                    cycle_cnt;
    logic [LNM_CH_W-1:0]   str_a [$];
    logic [LNM_CH_W-1:0]   str_b [$];

    levenshtein_near_match_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lnm_distance_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_data       (req_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_data       (res_data),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        res_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        sent_items     = 0;
        cycle_cnt      = 0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("levenshtein_near_match_unit_tb failed");
            $finish;
        end
    end

    // hold off the result side for a requested stretch, else stall at random
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [LNM_CH_W-1:0] pick_char(input bit narrow,
                                                      input logic [LNM_CH_W-1:0] base);
        if (narrow)
            return LNM_CH_W'(base + $urandom_range(0, 2));
        return LNM_CH_W'($urandom_range(0, 255));
    endfunction

    task automatic send_req(input logic [1:0] func, input logic [LNM_CH_W-1:0] ch);
        lnm_req_t item;
        item.func = func;
        item.ch   = ch;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (!req_ready);
        if (func != FUNC_UNUSED)
            sent_items++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_near_max(input logic [LNM_DIST_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic emit_strings(input int noise_pct);
        int i;
        int j;
        i = 0;
        j = 0;
        while (i < str_a.size() || j < str_b.size())
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_req(FUNC_UNUSED, LNM_CH_W'($urandom_range(0, 255)));
            if (j >= str_b.size() || (i < str_a.size() && $urandom_range(0, 1)))
            begin
                send_req(FUNC_APPEND_FIRST, str_a[i]);
                i++;
            end
            else
            begin
                send_req(FUNC_APPEND_SECOND, str_b[j]);
                j++;
            end
        end
        send_req(FUNC_COMPUTE, LNM_CH_W'($urandom_range(0, 255)));
    endtask

    task automatic fill_random(input int len_a, input int len_b);
        str_a.delete();
        str_b.delete();
        repeat (len_a) str_a.push_back(LNM_CH_W'($urandom_range(0, 255)));
        repeat (len_b) str_b.push_back(LNM_CH_W'($urandom_range(0, 255)));
    endtask

    task automatic build_similar();
        int                  len;
        int                  pos;
        bit                  narrow;
        logic [LNM_CH_W-1:0] base;
        str_a.delete();
        str_b.delete();
        narrow = 1'($urandom_range(0, 1));
        base   = LNM_CH_W'($urandom_range(0, 255));
        len    = $urandom_range(0, 8);
        repeat (len) str_a.push_back(pick_char(narrow, base));
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(0, 8);
            repeat (len) str_b.push_back(pick_char(narrow, base));
        end
        else
        begin
            str_b = str_a;
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        if (str_b.size() > 0)
                        begin
                            pos        = $urandom_range(0, str_b.size() - 1);
                            str_b[pos] = pick_char(narrow, base);
                        end
                    end
                    1:
                    begin
                        pos = $urandom_range(0, str_b.size());
                        str_b.insert(pos, pick_char(narrow, base));
                    end
                    default:
                    begin
                        if (str_b.size() > 0)
                            str_b.delete($urandom_range(0, str_b.size() - 1));
                    end
                endcase
            end
        end
    endtask

    task automatic build_long();
        if ($urandom_range(0, 1))
            fill_random($urandom_range(240, 260), $urandom_range(0, 3));
        else
            fill_random($urandom_range(0, 3), $urandom_range(240, 260));
    endtask

    task automatic run_random(input int n_items, input int pause_pct, input int long_pct);
        int stop_at;
        int r;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1))
                        send_req(FUNC_UNUSED, LNM_CH_W'($urandom_range(0, 255)));
                    else
                        send_req(2'($urandom_range(0, 1)), LNM_CH_W'($urandom_range(0, 255)));
                end
            end
            else
            begin
                if (r < 6 + long_pct)
                    build_long();
                else
                    build_similar();
                emit_strings(5);
                if ($urandom_range(0, 99) < pause_pct)
                    drain();
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, near_max at its reset value
        send_req(FUNC_COMPUTE, 8'h00);
        send_req(FUNC_UNUSED, 8'hA5);
        send_req(FUNC_COMPUTE, 8'hFF);
        send_req(FUNC_APPEND_SECOND, 8'h00);
        send_req(FUNC_APPEND_SECOND, 8'hFF);
        send_req(FUNC_APPEND_SECOND, 8'h7F);
        send_req(FUNC_COMPUTE, 8'h00);
        send_req(FUNC_APPEND_FIRST, 8'h00);
        send_req(FUNC_APPEND_SECOND, 8'h00);
        send_req(FUNC_UNUSED, 8'h5A);
        send_req(FUNC_COMPUTE, 8'h00);
        send_req(FUNC_APPEND_FIRST, 8'hFF);
        send_req(FUNC_APPEND_FIRST, 8'h01);
        send_req(FUNC_APPEND_SECOND, 8'h01);
        send_req(FUNC_COMPUTE, 8'h00);
        send_req(FUNC_APPEND_SECOND, 8'h61);
        send_req(FUNC_APPEND_SECOND, 8'h62);
        send_req(FUNC_APPEND_SECOND, 8'h63);
        send_req(FUNC_APPEND_SECOND, 8'h64);
        send_req(FUNC_APPEND_SECOND, 8'h65);
        send_req(FUNC_APPEND_SECOND, 8'h66);
        send_req(FUNC_COMPUTE, 8'h00);
        drain();

        set_near_max(9'd0);
        run_random(30, 0, 0);
        drain();

        set_near_max(9'd256);
        send_idle_pct = 74;
        run_random(30, 0, 0);
        drain();

        set_near_max(9'd255);
        send_idle_pct  = 0;
        recv_stall_pct = 74;
        run_random(30, 0, 0);
        drain();

        set_near_max(9'($urandom_range(1, 8)));
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        run_random(30, 15, 0);
        drain();

        // long result hold-off while requests keep coming
        set_near_max(9'd3);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 400;
        run_random(50, 0, 0);
        drain();

        // full-length strings and dropped characters on both sides
        set_near_max(9'd256);
        fill_random(LNM_MAX_LEN + 1, LNM_MAX_LEN + 1);
        emit_strings(0);
        drain();

        if (mismatch_count == 0 && pending_count == 0)
            $display("levenshtein_near_match_unit_tb passed");
        else
            $display("levenshtein_near_match_unit_tb failed");
        $finish;
    end

endmodule

@@ levenshtein_near_match_unit.f @@
hdl/lnm_pkg.sv
hdl/lnm_front.sv
hdl/lnm_queue.sv
hdl/lnm_back.sv
hdl/levenshtein_near_match_unit.sv
hdl/lnm_checker.sv
dv/lnm_distance_checker.sv
dv/levenshtein_near_match_unit_tb.sv
